[rtl/json_string_escape_utf8_check_assert.svh]
// ============================================================================
// JSON string quoter assertion macros
// Shared concurrent assertion forms, clocked on clk with active-low reset.
// ============================================================================
`ifndef JSON_STRING_ESCAPE_UTF8_CHECK_ASSERT_SVH
`define JSON_STRING_ESCAPE_UTF8_CHECK_ASSERT_SVH

// same-cycle implication
`define JSEU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jseu: assertion failed");

// next-cycle implication
`define JSEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jseu: assertion failed");

`endif

[rtl/jseu_pkg.sv]
// ============================================================================
// jseu_pkg
// Types, codes and helpers shared by the JSON string quoter with UTF-8 check.
// ============================================================================
package jseu_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [7:0] LEAD2_LO = 8'hc2;
    localparam logic [7:0] LEAD2_HI = 8'hdf;
    localparam logic [7:0] LEAD3_LO = 8'he0;
    localparam logic [7:0] LEAD3_HI = 8'hef;
    localparam logic [7:0] LEAD4_LO = 8'hf0;
    localparam logic [7:0] LEAD4_HI = 8'hf4;

    localparam int unsigned SCALAR_W = 21;
    localparam logic [SCALAR_W-1:0] MIN_CLS1   = 21'h00080;
    localparam logic [SCALAR_W-1:0] MIN_CLS2   = 21'h00800;
    localparam logic [SCALAR_W-1:0] MIN_CLS3   = 21'h10000;
    localparam logic [SCALAR_W-1:0] SCALAR_MAX = 21'h10ffff;
    localparam logic [SCALAR_W-1:0] SURR_LO    = 21'h00d800;
    localparam logic [SCALAR_W-1:0] SURR_HI    = 21'h00dfff;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_LEAD = 3'd1;
    localparam logic [2:0] ERR_TRUNC    = 3'd2;
    localparam logic [2:0] ERR_BAD_CONT = 3'd3;
    localparam logic [2:0] ERR_BAD_SCAL = 3'd4;

    localparam logic [1:0] KIND_PLAIN   = 2'd0;
    localparam logic [1:0] KIND_ESC     = 2'd1;
    localparam logic [1:0] KIND_UNICODE = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       empty_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_string;
        logic [2:0] error_code;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       empty;
        logic [1:0] kind;
        logic [2:0] err;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            r = CH_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

    function automatic logic [SCALAR_W-1:0] min_scalar(input logic [1:0] cls);
        logic [SCALAR_W-1:0] r;
        unique case (cls)
            2'd1:    r = MIN_CLS1;
            2'd2:    r = MIN_CLS2;
            default: r = MIN_CLS3;
        endcase
        return r;
    endfunction

endpackage

[rtl/jseu_front.sv]
// ============================================================================
// jseu_front
// Accepts raw bytes, runs the UTF-8 check and classifies the escape form.
// ============================================================================
module jseu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                raw_valid,
    output logic                raw_stall,
    input  jseu_pkg::in_item_t  raw_data,
    input  jseu_pkg::q_status_t q_status,
    output logic                push,
    output jseu_pkg::desc_t     push_desc
);
    import jseu_pkg::*;

    logic [1:0]          pc_reg, pc_next;
    logic [SCALAR_W-1:0] acc_reg, acc_next;
    logic [1:0]          cls_reg, cls_next;
    logic [2:0]          err_reg, err_next;
    logic [7:0]          b;
    logic [1:0]          kind;

    assign raw_stall = q_status.full;
    assign push      = raw_valid && !q_status.full;
    assign b         = raw_data.data_byte;

    always_comb
    begin
        pc_next  = pc_reg;
        acc_next = acc_reg;
        cls_next = cls_reg;
        err_next = err_reg;
        if (raw_data.first_byte || raw_data.empty_string)
        begin
            pc_next  = 2'd0;
            acc_next = '0;
            cls_next = 2'd0;
            err_next = ERR_NONE;
        end
        if (!raw_data.empty_string)
        begin
            if (pc_next == 2'd0)
            begin
                priority if (!b[7])
                begin
                    pc_next = 2'd0;
                end
                else if (b >= LEAD2_LO && b <= LEAD2_HI)
                begin
                    pc_next  = 2'd1;
                    acc_next = {16'd0, b[4:0]};
                    cls_next = 2'd1;
                end
                else if (b >= LEAD3_LO && b <= LEAD3_HI)
                begin
                    pc_next  = 2'd2;
                    acc_next = {17'd0, b[3:0]};
                    cls_next = 2'd2;
                end
                else if (b >= LEAD4_LO && b <= LEAD4_HI)
                begin
                    pc_next  = 2'd3;
                    acc_next = {18'd0, b[2:0]};
                    cls_next = 2'd3;
                end
                else
                begin
                    if (err_next == ERR_NONE)
                    begin
                        err_next = ERR_BAD_LEAD;
                    end
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                if (err_next == ERR_NONE)
                begin
                    err_next = ERR_BAD_CONT;
                end
                pc_next  = 2'd0;
                acc_next = '0;
                cls_next = 2'd0;
            end
            else
            begin
                acc_next = {acc_next[SCALAR_W-7:0], b[5:0]};
                pc_next  = pc_next - 2'd1;
                if (pc_next == 2'd0)
                begin
                    if ((acc_next < min_scalar(cls_next) || acc_next > SCALAR_MAX
                         || (acc_next >= SURR_LO && acc_next <= SURR_HI))
                        && err_next == ERR_NONE)
                    begin
                        err_next = ERR_BAD_SCAL;
                    end
                    acc_next = '0;
                    cls_next = 2'd0;
                end
            end
            if (raw_data.last_byte)
            begin
                if (pc_next != 2'd0 && err_next == ERR_NONE)
                begin
                    err_next = ERR_TRUNC;
                end
                pc_next  = 2'd0;
                acc_next = '0;
                cls_next = 2'd0;
            end
        end
    end

    always_comb
    begin
        priority if (b == CH_QUOTE || b == CH_BSLASH)
        begin
            kind = KIND_ESC;
        end
        else if (b < CTRL_LIMIT)
        begin
            kind = KIND_UNICODE;
        end
        else
        begin
            kind = KIND_PLAIN;
        end
    end

    assign push_desc.data  = b;
    assign push_desc.first = raw_data.first_byte;
    assign push_desc.last  = raw_data.last_byte;
    assign push_desc.empty = raw_data.empty_string;
    assign push_desc.kind  = kind;
    assign push_desc.err   = err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= 2'd0;
            acc_reg <= '0;
            cls_reg <= 2'd0;
            err_reg <= ERR_NONE;
        end
        else if (push)
        begin
            pc_reg  <= pc_next;
            acc_reg <= acc_next;
            cls_reg <= cls_next;
            err_reg <= err_next;
        end
    end

endmodule

[rtl/jseu_queue.sv]
// ============================================================================
// jseu_queue
// Small FIFO of classified items between the front and back parts.
// ============================================================================
module jseu_queue #(
    parameter int unsigned DEPTH = jseu_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jseu_pkg::desc_t     push_desc,
    input  logic                pop,
    output jseu_pkg::desc_t     head_desc,
    output jseu_pkg::q_status_t status
);
    import jseu_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    desc_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_desc    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/jseu_back.sv]
// ============================================================================
// jseu_back
// Expands each classified item into output bytes through an output register.
// ============================================================================
module jseu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jseu_pkg::desc_t      head_desc,
    input  jseu_pkg::q_status_t  q_status,
    output logic                 pop,
    output logic                 json_valid,
    input  logic                 json_stall,
    output jseu_pkg::out_item_t  json_data
);
    import jseu_pkg::*;

    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       load;
    logic [3:0] body_len;
    logic [3:0] total;
    logic [2:0] j;
    logic       is_last;
    logic [7:0] body_byte;
    logic [7:0] sel_byte;
    logic       sel_eos;

    assign load = !q_status.empty && (!out_valid_reg || !json_stall);

    always_comb
    begin
        unique case (head_desc.kind)
            KIND_ESC:     body_len = 4'd2;
            KIND_UNICODE: body_len = 4'd6;
            default:      body_len = 4'd1;
        endcase
        if (head_desc.empty)
        begin
            total = 4'd2;
        end
        else
        begin
            total = body_len + {3'd0, head_desc.first} + {3'd0, head_desc.last};
        end
        is_last = ({1'b0, step_reg} + 4'd1 == total);
        j = step_reg - {2'd0, head_desc.first};
    end

    always_comb
    begin
        unique case (head_desc.kind)
            KIND_ESC:
            begin
                body_byte = (j == 3'd0) ? CH_BSLASH : head_desc.data;
            end
            KIND_UNICODE:
            begin
                unique case (j)
                    3'd0:         body_byte = CH_BSLASH;
                    3'd1:         body_byte = CH_U;
                    3'd2, 3'd3:   body_byte = CH_ZERO;
                    3'd4:         body_byte = hex_digit(head_desc.data[7:4]);
                    default:      body_byte = hex_digit(head_desc.data[3:0]);
                endcase
            end
            default:
            begin
                body_byte = head_desc.data;
            end
        endcase
    end

    always_comb
    begin
        sel_byte = CH_QUOTE;
        sel_eos  = 1'b0;
        priority if (head_desc.empty)
        begin
            sel_eos = (step_reg == 3'd1);
        end
        else if (head_desc.first && step_reg == 3'd0)
        begin
            sel_eos = 1'b0;
        end
        else if ({1'b0, j} < body_len)
        begin
            sel_byte = body_byte;
        end
        else
        begin
            sel_eos = 1'b1;
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next         = 1'b1;
            out_next.out_byte      = sel_byte;
            out_next.end_of_run    = is_last;
            out_next.end_of_string = sel_eos;
            out_next.error_code    = head_desc.err;
            if (is_last)
            begin
                step_next = 3'd0;
                pop       = 1'b1;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
        else if (!json_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign json_valid = out_valid_reg;
    assign json_data  = out_reg;

endmodule

[rtl/json_string_escape_utf8_check.sv]
// ============================================================================
// json_string_escape_utf8_check
// Quotes and escapes a byte string as JSON and checks it as strict UTF-8.
// ============================================================================
// Input channel raw_*: one string byte per item with first/last marks, or an
// empty-string item. Output channel json_*: one output byte per item, with
// end_of_run on the last byte an input item causes, end_of_string on the
// closing quote and a sticky UTF-8 error code on every byte.
// The front part checks and classifies each input item in the cycle it is
// accepted and writes it into a QUEUE_DEPTH-entry queue. The back part
// expands the queue head into the output register, one output byte per
// cycle while the output register is empty or json_stall is low.
// The first result of an item passes through the queue and then the output
// register. An item gives as many output bytes as it has results: 1 for a
// plain byte, 2 for a quote or backslash, 6 for a control byte, plus one per
// opening or closing quote. The front keeps accepting until the queue is full.
// A stalled output holds its byte; raw_stall rises once the queue fills.
// Reset clears the check state, the queue and the output valid.
// ============================================================================
`include "json_string_escape_utf8_check_assert.svh"

module json_string_escape_utf8_check #(
    parameter int unsigned QUEUE_DEPTH = jseu_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                raw_valid,
    output logic                raw_stall,
    input  jseu_pkg::in_item_t  raw_data,
    output logic                json_valid,
    input  logic                json_stall,
    output jseu_pkg::out_item_t json_data
);
    import jseu_pkg::*;

    q_status_t q_status;
    logic      push;
    logic      pop;
    desc_t     push_desc;
    desc_t     head_desc;

    jseu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_stall (raw_stall),
        .raw_data  (raw_data),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    jseu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .status    (q_status)
    );

    jseu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_desc  (head_desc),
        .q_status   (q_status),
        .pop        (pop),
        .json_valid (json_valid),
        .json_stall (json_stall),
        .json_data  (json_data)
    );

    `JSEU_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, raw_valid && !raw_stall, !q_status.empty)
    `JSEU_ASSERT_IMPL(a_eos_ends_run, clk, rst_n, json_valid && json_data.end_of_string, json_data.end_of_run)
    `JSEU_ASSERT_IMPL(a_err_range, clk, rst_n, json_valid, json_data.error_code <= ERR_BAD_SCAL)

endmodule
